// ----- rtl/ngahr_pkg.sv -----
package ngahr_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CHANNEL_W  = 3;
  localparam int STAGE_W    = 3;
  localparam int THR_W      = 16;
  localparam int STEP_W     = 17;
  localparam int COUNT_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 16;

  localparam logic [STEP_W-1:0]  UNITY     = STEP_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 2'd3;

  localparam logic [THR_W-1:0]   THRESHOLD_RST    = 16'd1024;
  localparam logic [STEP_W-1:0]  ATTACK_STEP_RST  = 17'd66;
  localparam logic [COUNT_W-1:0] HOLD_LENGTH_RST  = 24'd4800;
  localparam logic [STEP_W-1:0]  RELEASE_STEP_RST = 17'd13;

  typedef enum logic [STAGE_W-1:0] {
    ST_CLOSED  = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_OPEN    = 3'd2,
    ST_HOLD    = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

endpackage

// ----- rtl/ngahr_if.sv -----
interface ngahr_in_if #(
  parameter int SAMPLE_BITS = ngahr_pkg::SAMPLE_BITS_DEF
);
  import ngahr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CHANNEL_W-1:0]          channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface ngahr_out_if #(
  parameter int SAMPLE_BITS = ngahr_pkg::SAMPLE_BITS_DEF
);
  import ngahr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CHANNEL_W-1:0]          channel_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [STAGE_W-1:0]            stage_out;

  modport source (output valid, output channel_out, output sample_out, output stage_out,
                  input ready);
  modport sink   (input valid, input channel_out, input sample_out, input stage_out,
                  output ready);
endinterface

// ----- rtl/ngahr_ram.sv -----
module ngahr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/noise_gate_ahr_top.sv -----
// Multi-channel noise gate with attack, hold and release. Each word carries one
// signed sample and its channel; each accepted word yields exactly one output
// word with the gated sample and the channel's gate stage after that sample.
// Per-channel stage and elapsed-sample count live in a small RAM that is read,
// updated and written back once per word; channels are cleared to closed at
// reset by per-entry valid bits, so no clearing pass is needed. Each word goes
// through a RAM read, ramp multiply, gain multiply with write-back and output
// load, in that order, and words are handled one at a time; the next word is
// taken while the previous result still waits in the output register.
// Configuration writes must only be issued while no word is in flight.
module noise_gate_ahr_top #(
  parameter int CHANNELS    = ngahr_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = ngahr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ngahr_in_if.sink                          in_ch,
  ngahr_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [ngahr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ngahr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ngahr_pkg::*;

  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = STAGE_W + COUNT_W;
  localparam int PROD1_W = COUNT_W + STEP_W;
  localparam int GAIN_W  = STEP_W + 1;
  localparam int PROD2_W = SAMPLE_BITS + GAIN_W;
  localparam int CMP_W   = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_SCALE, S_DONE} state_t;

  // configuration
  logic [THR_W-1:0]   threshold;
  logic [STEP_W-1:0]  attack_step;
  logic [COUNT_W-1:0] hold_length;
  logic [STEP_W-1:0]  release_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      attack_step  <= ATTACK_STEP_RST;
      hold_length  <= HOLD_LENGTH_RST;
      release_step <= RELEASE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data[THR_W-1:0];
        REG_ATTACK_STEP:  attack_step  <= cfg_data[STEP_W-1:0];
        REG_HOLD_LENGTH:  hold_length  <= cfg_data[COUNT_W-1:0];
        REG_RELEASE_STEP: release_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state;

  logic                          accept;
  logic [AW-1:0]                 in_addr;
  logic                          in_oob;
  logic [CHANNELS-1:0]           ent_valid;
  logic                          rd_ok;
  logic [ENTRY_W-1:0]            rd_data;

  logic [AW-1:0]                 addr;
  logic                          oob;
  logic [CHANNEL_W-1:0]          chan;
  logic signed [SAMPLE_BITS-1:0] smp;
  stage_t                        stage;
  logic [COUNT_W-1:0]            e_inc;
  logic [PROD1_W-1:0]            p1;
  logic [PROD2_W-1:0]            p2;
  stage_t                        st_res;

  logic                          out_valid;
  logic [CHANNEL_W-1:0]          out_chan;
  logic [SAMPLE_BITS-1:0]        out_sample;
  stage_t                        out_stage;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_addr     = AW'(in_ch.channel);
  assign in_oob      = (32'(in_ch.channel) >= CHANNELS);

  // RAM read result
  stage_t             stage_rd;
  logic [COUNT_W-1:0] e_rd;
  logic [COUNT_W-1:0] e_calc;
  logic [STEP_W-1:0]  step_sel;

  always_comb begin
    stage_rd = ST_CLOSED;
    e_rd     = '0;
    if (rd_ok) begin
      stage_rd = stage_t'(rd_data[ENTRY_W-1:COUNT_W]);
      e_rd     = rd_data[COUNT_W-1:0];
    end
    e_calc   = (e_rd == COUNT_MAX) ? e_rd : e_rd + COUNT_W'(1);
    step_sel = (stage_rd == ST_RELEASE) ? release_step : attack_step;
  end

  // stage decision and gain
  logic                    g_full;
  logic [STEP_W-1:0]       g;
  logic [STEP_W-1:0]       gain;
  stage_t                  st_new;
  logic [COUNT_W-1:0]      e_new;
  logic signed [CMP_W-1:0] s_x;
  logic signed [CMP_W-1:0] t_x;
  logic                    above;
  logic signed [GAIN_W-1:0]  gain_s;
  logic signed [PROD2_W-1:0] p2_calc;

  always_comb begin
    g_full = (p1 >= PROD1_W'(UNITY));
    g      = g_full ? UNITY : p1[STEP_W-1:0];
    s_x    = CMP_W'(smp);
    t_x    = CMP_W'($signed(threshold));
    above  = (s_x >= t_x);
    gain   = '0;
    st_new = ST_CLOSED;
    e_new  = e_inc;
    case (stage)
      ST_ATTACK: begin
        gain   = g;
        st_new = g_full ? ST_OPEN : ST_ATTACK;
      end
      ST_OPEN: begin
        gain   = UNITY;
        st_new = ST_OPEN;
        if (!above) begin
          st_new = ST_HOLD;
          e_new  = '0;
        end
      end
      ST_HOLD: begin
        gain   = UNITY;
        st_new = ST_HOLD;
        if (e_inc >= hold_length) begin
          st_new = ST_RELEASE;
          e_new  = '0;
        end
      end
      ST_RELEASE: begin
        gain   = UNITY - g;
        st_new = g_full ? ST_CLOSED : ST_RELEASE;
      end
      default: begin
        if (above) begin
          st_new = ST_ATTACK;
          e_new  = '0;
        end
      end
    endcase
    if (oob) begin
      gain   = '0;
      st_new = ST_CLOSED;
    end
    gain_s  = $signed({1'b0, gain});
    p2_calc = smp * gain_s;
  end

  // round toward zero
  logic [PROD2_W-1:0] p2_adj;
  assign p2_adj = p2 + (p2[PROD2_W-1] ? PROD2_W'((1 << FRAC_W) - 1) : '0);

  logic ram_we;
  assign ram_we = (state == S_SCALE) && !oob;

  ngahr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({st_new, e_new}),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (ram_we) begin
      ent_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE a taken word is replaced by the new one below
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr  <= in_addr;
            oob   <= in_oob;
            chan  <= in_ch.channel;
            smp   <= in_ch.sample_in;
            rd_ok <= !in_oob && ent_valid[in_addr];
            state <= S_CALC;
          end
        end
        S_CALC: begin
          stage <= stage_rd;
          e_inc <= e_calc;
          p1    <= e_calc * step_sel;
          state <= S_SCALE;
        end
        S_SCALE: begin
          p2     <= p2_calc;
          st_res <= st_new;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_chan   <= chan;
            out_sample <= p2_adj[FRAC_W +: SAMPLE_BITS];
            out_stage  <= st_res;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.channel_out = out_chan;
  assign out_ch.sample_out  = out_sample;
  assign out_ch.stage_out   = out_stage;

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CALC))
    else $error("accepted word did not start a RAM read");

  a_write_once: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (state == S_DONE) && !ram_we)
    else $error("state write-back not single per word");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output loaded outside of done state");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((ent_valid & $past(ent_valid)) == $past(ent_valid)))
    else $error("entry valid bit cleared outside reset");

endmodule

// ----- tb/sv/ngahr_checker.sv -----
`timescale 1ns / 100ps

module ngahr_checker (
  input  logic                             clk,
  input  logic                             rst,
  ngahr_in_if                              in_mon,
  ngahr_out_if                             out_mon,
  input  logic                             cfg_we,
  input  logic [ngahr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ngahr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               pending,
  output int                               errors
);
  import ngahr_pkg::*;

  localparam longint UNITY_L = longint'(UNITY);

  typedef struct packed {
    logic [CHANNEL_W-1:0]       channel;
    logic [SAMPLE_BITS_DEF-1:0] sample;
    stage_t                     stage;
  } gated_t;

  logic signed [THR_W-1:0] thr_cfg;
  logic [STEP_W-1:0]       atk_cfg;
  logic [COUNT_W-1:0]      hold_cfg;
  logic [STEP_W-1:0]       rel_cfg;

  stage_t             gate_stage_m [CHANNELS_DEF];
  logic [COUNT_W-1:0] elapsed_m    [CHANNELS_DEF];
  gated_t             gated_q [$];

  function automatic longint ramp_gain(logic [COUNT_W-1:0] e, logic [STEP_W-1:0] step);
    longint g;
    g = longint'(e) * longint'(step);
    return (g > UNITY_L) ? UNITY_L : g;
  endfunction

  // advances the addressed channel and returns the gated word
  function automatic gated_t gate_step(logic [CHANNEL_W-1:0] ch,
                                       logic signed [SAMPLE_BITS_DEF-1:0] s);
    logic [COUNT_W-1:0] e;
    stage_t             st;
    longint             gain;
    longint             level;
    gated_t             w;
    e = elapsed_m[ch];
    if (e != COUNT_MAX) e = e + 1'b1;
    st = gate_stage_m[ch];
    level = 0;
    case (st)
      ST_ATTACK: begin
        gain = ramp_gain(e, atk_cfg);
        level = (longint'(s) * gain) / UNITY_L;
        if (gain >= UNITY_L) st = ST_OPEN;
      end
      ST_OPEN: begin
        level = longint'(s);
        if (s < thr_cfg) begin
          st = ST_HOLD;
          e = '0;
        end
      end
      ST_HOLD: begin
        level = longint'(s);
        if (e >= hold_cfg) begin
          st = ST_RELEASE;
          e = '0;
        end
      end
      ST_RELEASE: begin
        gain = ramp_gain(e, rel_cfg);
        level = (longint'(s) * (UNITY_L - gain)) / UNITY_L;
        if (gain >= UNITY_L) st = ST_CLOSED;
      end
      default: begin
        st = ST_CLOSED;
        if (s >= thr_cfg) begin
          st = ST_ATTACK;
          e = '0;
        end
      end
    endcase
    gate_stage_m[ch] = st;
    elapsed_m[ch] = e;
    w.channel = ch;
    w.sample = level[SAMPLE_BITS_DEF-1:0];
    w.stage = st;
    return w;
  endfunction

  always @(posedge clk) begin
    gated_t exp_w;
    if (rst) begin
      thr_cfg = THRESHOLD_RST;
      atk_cfg = ATTACK_STEP_RST;
      hold_cfg = HOLD_LENGTH_RST;
      rel_cfg = RELEASE_STEP_RST;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        gate_stage_m[i] = ST_CLOSED;
        elapsed_m[i] = '0;
      end
      gated_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:    thr_cfg = cfg_data[THR_W-1:0];
          REG_ATTACK_STEP:  atk_cfg = cfg_data[STEP_W-1:0];
          REG_HOLD_LENGTH:  hold_cfg = cfg_data[COUNT_W-1:0];
          REG_RELEASE_STEP: rel_cfg = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (gated_q.size() == 0) begin
          $error("unexpected output word: channel %0d sample %0d stage %0d",
                 out_mon.channel_out, out_mon.sample_out, out_mon.stage_out);
          errors++;
        end else begin
          exp_w = gated_q.pop_front();
          if (out_mon.channel_out !== exp_w.channel) begin
            $error("channel_out: expected %0d, got %0d", exp_w.channel, out_mon.channel_out);
            errors++;
          end
          if (out_mon.sample_out !== exp_w.sample) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(exp_w.sample), out_mon.sample_out);
            errors++;
          end
          if (out_mon.stage_out !== exp_w.stage) begin
            $error("stage_out: expected %0d, got %0d", exp_w.stage, out_mon.stage_out);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        gated_q.push_back(gate_step(in_mon.channel, in_mon.sample_in));
    end
    pending <= gated_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ngahr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 80;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int pending;
  int errors;
  int quiet_cycles;
  int cur_thr;
  bit no_idle;
  bit loud [CHANNELS_DEF];

  ngahr_in_if  in_ch ();
  ngahr_out_if out_ch ();

  noise_gate_ahr_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ngahr_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] gen_sample(bit is_loud);
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 99);
    if (r < 8) return r[0] ? 16'h7fff : 16'h8000;
    if (r < 20) return SAMPLE_BITS_DEF'($urandom);
    if (is_loud) begin
      lo = cur_thr;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = cur_thr - 1;
      if (hi < lo) begin
        lo = cur_thr;
        hi = 32767;
      end
    end
    return SAMPLE_BITS_DEF'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic int rand_step();
    if ($urandom_range(0, 9) == 0) return 65536;
    return 65536 / $urandom_range(1, 12) + $urandom_range(0, 50);
  endfunction

  function automatic int rand_thr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    return int'($urandom_range(0, 4000)) - 2000;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_gate(input int thr, input int atk, input int hold, input int rel);
    logic [THR_W-1:0] thr_bits;
    thr_bits = THR_W'(thr);
    wait_idle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr_bits));
    write_reg(REG_ATTACK_STEP, CFG_DATA_W'(atk));
    write_reg(REG_HOLD_LENGTH, CFG_DATA_W'(hold));
    write_reg(REG_RELEASE_STEP, CFG_DATA_W'(rel));
    cur_thr = thr;
  endtask

  task automatic send_word(input logic [CHANNEL_W-1:0] ch,
                           input logic signed [SAMPLE_BITS_DEF-1:0] s);
    int gap;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.channel <= ch;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int ch;
    int focus_ch;
    bit focus;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.channel = '0;
    in_ch.sample_in = '0;
    no_idle = 1'b0;
    cur_thr = 1024;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: just below and at threshold, then the slow attack ramp
    send_word(0, 1023);
    send_word(0, 1024);
    send_word(0, 32767);
    send_word(0, -32768);

    // one-word attack and release, zero hold: full cycle through every stage
    set_gate(0, 65536, 0, 65536);
    send_word(1, -1);
    send_word(1, 0);
    send_word(1, -32768);
    send_word(1, 32767);
    send_word(1, -32768);
    send_word(1, 5);
    send_word(1, -32768);

    // zero attack step keeps gain at zero
    set_gate(-32768, 0, 0, 0);
    send_word(2, -32768);
    send_word(2, -32768);
    send_word(2, 32767);

    // oversized attack step, zero release step keeps full gain
    set_gate(32767, 131071, 0, 0);
    send_word(4, 32767);
    send_word(4, 100);
    send_word(4, -1);
    send_word(4, -5);
    send_word(4, -32768);
    send_word(4, 32767);
    send_word(0, -32768);
    send_word(2, 1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: set_gate(-32768, 65536, 0, 131071);
        2: set_gate(32767, 1, 16777215, 1);
        default: set_gate(rand_thr(), rand_step(), $urandom_range(0, 12), rand_step());
      endcase
      focus = ($urandom_range(0, 1) == 1);
      focus_ch = $urandom_range(0, 7);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        ch = (focus && $urandom_range(0, 3) != 0) ? focus_ch : $urandom_range(0, 7);
        if ($urandom_range(0, 7) == 0) loud[ch] = !loud[ch];
        send_word(CHANNEL_W'(ch), gen_sample(loud[ch]));
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
